// File: rtl/core/ppg_pkg.sv
// shared constants, types and bitmap functions for the pose generator
package ppg_pkg;

	localparam int GRID_SIDE  = 7;
	localparam int CELLS      = GRID_SIDE * GRID_SIDE;
	localparam int ROT_STEPS  = 4;
	localparam int GEN_STEPS  = 2 * ROT_STEPS;
	localparam int MAX_POSES  = 8;
	localparam int SHAPE_W    = 49;
	localparam int IDX_W      = 3;
	localparam int DIM_W      = 3;
	localparam int CNT_W      = $clog2(MAX_POSES + 1);
	localparam int SEQ_W      = $clog2((GEN_STEPS > MAX_POSES) ? GEN_STEPS : MAX_POSES);
	localparam int SIDE_W     = $clog2(GRID_SIDE);
	localparam int SH_W       = $clog2(CELLS);
	localparam int S_TDATA_W  = ((SHAPE_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = SHAPE_W + IDX_W + 2 * DIM_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

	typedef logic [CELLS-1:0] grid_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GEN,
		ST_FLUSH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic             load;
		logic             gen;
		logic             mirror;
		logic             emit;
		logic             last;
		logic [SEQ_W-1:0] idx;
	} ppg_cmd_t;

	typedef struct packed {
		logic             out_free;
		logic [CNT_W-1:0] pose_cnt;
	} ppg_sts_t;

	function automatic grid_t shape_to_grid(input logic [SHAPE_W-1:0] s);
		grid_t g;
		g = '0;
		for (int i = 0; i < CELLS; i++) begin
			if (i < SHAPE_W) begin
				g[i] = s[i];
			end
		end
		return g;
	endfunction

	function automatic logic [SHAPE_W-1:0] grid_to_shape(input grid_t g);
		logic [SHAPE_W-1:0] s;
		s = '0;
		for (int i = 0; i < SHAPE_W; i++) begin
			if (i < CELLS) begin
				s[i] = g[i];
			end
		end
		return s;
	endfunction

	// new[y][x] = old[x][side-1-y]
	function automatic grid_t rotate_ccw(input grid_t b);
		grid_t r;
		r = '0;
		for (int y = 0; y < GRID_SIDE; y++) begin
			for (int x = 0; x < GRID_SIDE; x++) begin
				r[y*GRID_SIDE + x] = b[x*GRID_SIDE + GRID_SIDE - 1 - y];
			end
		end
		return r;
	endfunction

	// new[y][x] = old[x][y]
	function automatic grid_t mirror_diag(input grid_t b);
		grid_t r;
		r = '0;
		for (int y = 0; y < GRID_SIDE; y++) begin
			for (int x = 0; x < GRID_SIDE; x++) begin
				r[y*GRID_SIDE + x] = b[x*GRID_SIDE + y];
			end
		end
		return r;
	endfunction

	function automatic logic [GRID_SIDE-1:0] row_any(input grid_t b);
		logic [GRID_SIDE-1:0] a;
		a = '0;
		for (int y = 0; y < GRID_SIDE; y++) begin
			for (int x = 0; x < GRID_SIDE; x++) begin
				a[y] = a[y] | b[y*GRID_SIDE + x];
			end
		end
		return a;
	endfunction

	function automatic logic [GRID_SIDE-1:0] col_any(input grid_t b);
		logic [GRID_SIDE-1:0] a;
		a = '0;
		for (int y = 0; y < GRID_SIDE; y++) begin
			for (int x = 0; x < GRID_SIDE; x++) begin
				a[x] = a[x] | b[y*GRID_SIDE + x];
			end
		end
		return a;
	endfunction

	// lowest set position, zero when none
	function automatic logic [SIDE_W-1:0] first_set(input logic [GRID_SIDE-1:0] v);
		logic [SIDE_W-1:0] f;
		f = '0;
		for (int i = GRID_SIDE - 1; i >= 0; i--) begin
			if (v[i]) begin
				f = SIDE_W'(i);
			end
		end
		return f;
	endfunction

	// one plus highest set position, masked to the field width
	function automatic logic [DIM_W-1:0] extent(input logic [GRID_SIDE-1:0] v);
		int e;
		e = 0;
		for (int i = 0; i < GRID_SIDE; i++) begin
			if (v[i]) begin
				e = i + 1;
			end
		end
		return DIM_W'(e);
	endfunction

	// drop empty top rows and left columns; empty stays empty
	function automatic grid_t pack_upper_left(input grid_t b);
		logic [SIDE_W-1:0] top;
		logic [SIDE_W-1:0] left;
		logic [SH_W-1:0]   sh;
		grid_t             t;
		grid_t             r;
		top  = first_set(row_any(b));
		left = first_set(col_any(b));
		sh   = SH_W'(top) * SH_W'(GRID_SIDE);
		t    = b >> sh;
		r    = '0;
		for (int y = 0; y < GRID_SIDE; y++) begin
			r[y*GRID_SIDE +: GRID_SIDE] = t[y*GRID_SIDE +: GRID_SIDE] >> left;
		end
		return r;
	endfunction

endpackage

// File: rtl/core/ppg_ctrl.sv
// sequencer for loading, candidate generation and result emission
module ppg_ctrl
	import ppg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  ppg_sts_t sts,
	output ppg_cmd_t cmd
);

	state_t           state_q;
	state_t           state_d;
	logic [SEQ_W-1:0] step_q;
	logic             gen_done;
	logic             is_last;

	assign gen_done = (step_q == SEQ_W'(GEN_STEPS - 1));
	assign is_last  = ((CNT_W'(step_q) + CNT_W'(1)) == sts.pose_cnt);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_GEN;
			ST_GEN:   if (gen_done) state_d = ST_FLUSH;
			ST_FLUSH: state_d = ST_EMIT;
			ST_EMIT:  if (sts.out_free && is_last) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.gen    = 1'b0;
		cmd.mirror = 1'b0;
		cmd.emit   = 1'b0;
		cmd.last   = is_last;
		cmd.idx    = step_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_GEN: begin
				cmd.gen    = 1'b1;
				cmd.mirror = (step_q == SEQ_W'(ROT_STEPS));
			end
			ST_FLUSH: begin
			end
			ST_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_GEN) begin
				step_q <= gen_done ? '0 : step_q + SEQ_W'(1);
			end else if (state_q == ST_EMIT && sts.out_free) begin
				step_q <= is_last ? '0 : step_q + SEQ_W'(1);
			end
		end
	end

endmodule

// File: rtl/core/ppg_dp.sv
// rotate and pack unit, pose store with duplicate check, output register
module ppg_dp
	import ppg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  ppg_cmd_t             cmd,
	output ppg_sts_t             sts,
	input  logic [SHAPE_W-1:0]   shape_bits,
	input  logic                 m_tready,
	output logic                 m_tvalid,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tlast
);

	grid_t            f_q;
	grid_t            pose_q [MAX_POSES];
	logic [CNT_W-1:0] cnt_q;
	grid_t            cand_s1;
	logic             cand_vld_s1;
	grid_t            src;
	grid_t            nxt;
	grid_t            rd_pose;
	logic             dup;
	logic             store;
	logic             m_tvalid_q;
	logic [SHAPE_W-1:0] out_bits_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic [DIM_W-1:0]   out_w_q;
	logic [DIM_W-1:0]   out_h_q;
	logic               out_last_q;

	// mirrored branch restarts from the shape as given
	assign src = cmd.mirror ? mirror_diag(pose_q[0]) : f_q;
	assign nxt = pack_upper_left(rotate_ccw(src));

	always_comb begin
		dup = 1'b0;
		for (int j = 0; j < MAX_POSES; j++) begin
			if ((CNT_W'(j) < cnt_q) && (pose_q[j] == cand_s1)) begin
				dup = 1'b1;
			end
		end
	end

	assign store   = cand_vld_s1 && !dup && (cnt_q < CNT_W'(MAX_POSES));
	assign rd_pose = pose_q[cmd.idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			cand_vld_s1 <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			cand_vld_s1 <= cmd.gen;
			if (cmd.load) begin
				cnt_q <= CNT_W'(1);
			end else if (store) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			f_q       <= shape_to_grid(shape_bits);
			pose_q[0] <= shape_to_grid(shape_bits);
		end else if (cmd.gen) begin
			f_q <= nxt;
		end
		if (cmd.gen) begin
			cand_s1 <= nxt;
		end
		if (store) begin
			pose_q[cnt_q[SEQ_W-1:0]] <= cand_s1;
		end
		if (cmd.emit) begin
			out_bits_q <= grid_to_shape(rd_pose);
			out_idx_q  <= IDX_W'(cmd.idx);
			out_w_q    <= extent(col_any(rd_pose));
			out_h_q    <= extent(row_any(rd_pose));
			out_last_q <= cmd.last;
		end
	end

	assign sts.out_free = !m_tvalid_q || m_tready;
	assign sts.pose_cnt = cnt_q;
	assign m_tvalid     = m_tvalid_q;
	assign m_tlast      = out_last_q;
	assign m_tdata      = M_TDATA_W'({out_h_q, out_w_q, out_idx_q, out_bits_q});

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_POSES))
		else $error("pose count beyond store depth");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (CNT_W'(cmd.idx) < cnt_q))
		else $error("emitting a pose that was never stored");

	a_last_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |-> (CNT_W'(cmd.idx) + CNT_W'(1) == cnt_q))
		else $error("last flag not on the final stored pose");

	a_cand_follows_gen: assert property (@(posedge clk) disable iff (!arst_n)
		cand_vld_s1 |-> $past(cmd.gen))
		else $error("candidate check without a generation step");
`endif

endmodule

// File: rtl/core/polyomino_pose_generator_top.sv
// top level of the polyomino pose generator
// Takes one 7x7 piece bitmap per transfer and returns its distinct free
// orientations, one transfer per pose: first the shape as given, then four
// counter-clockwise rotations packed to the upper-left, then four rotations
// of the shape mirrored about its main diagonal, packed the same way, with
// any repeat of an earlier pose dropped (one to eight poses, the final one
// flagged on m_axis_tlast). Each shape passes through a load step, eight
// generation steps in which the single rotate-and-pack unit produces one
// candidate each, a step that checks the last candidate against the pose
// store, then the emission of one pose per cycle into the output register
// as the downstream side takes them. A new shape is accepted while the last
// pose of the previous one still waits in the output register.
module polyomino_pose_generator_top
	import ppg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// shape input
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,   // shape_bits[48:0], zero padding
	// pose output
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,   // pose_bits[48:0], pose_index[51:49],
	                                             // pose_width[54:52], pose_height[57:55],
	                                             // zero padding
	output logic                 m_axis_tlast    // last_pose
);

	ppg_cmd_t cmd;
	ppg_sts_t sts;

	// sequencer: load, eight generation steps, final check, emission
	ppg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: bits beyond the grid are dropped at load
	ppg_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.shape_bits (s_axis_tdata[SHAPE_W-1:0]),
		.m_tready   (m_axis_tready),
		.m_tvalid   (m_axis_tvalid),
		.m_tdata    (m_axis_tdata),
		.m_tlast    (m_axis_tlast)
	);

endmodule

// File: dv/polyomino_pose_generator_top_tb.sv
// testbench for the polyomino pose generator: predicts every orientation and checks each pose
`timescale 1ns / 1ps

module polyomino_pose_generator_top_tb;
	import ppg_pkg::*;

	localparam int IDLE_PCT    = 11;        // chance in a hundred that a side idles
	localparam int CYCLE_LIMIT = 300000;    // far beyond the slowest correct run
	localparam int CALM_FROM   = 220;       // pieces sent before the no-idle stretch
	localparam int CALM_TO     = 330;       // end of the no-idle stretch
	localparam int RANDOM_HALF = 250;       // random pieces per random phase
	localparam int TAIL_CYCLES = 40;        // wait after the last pose

	typedef logic [SHAPE_W-1:0] piece_t;

	// one orientation as it should leave the block
	typedef struct packed {
		piece_t           bits;
		logic [IDX_W-1:0] index;
		logic [DIM_W-1:0] wid;
		logic [DIM_W-1:0] hgt;
		logic             last;
	} pose_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic                 m_axis_tlast;

	piece_t pieces_q[$];    // shapes waiting to be sent
	pose_t  poses_due[$];   // poses predicted but not yet seen
	int     pieces_sent = 0;
	int     poses_checked = 0;
	int     faults = 0;
	int     cycles = 0;
	logic   calm;

	assign calm = (pieces_sent >= CALM_FROM) && (pieces_sent < CALM_TO);

	polyomino_pose_generator_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #10 clk = ~clk;

	// quarter turn counter-clockwise: cell (y, x) takes old cell (x, side-1-y)
	function automatic piece_t turn_left(input piece_t b);
		piece_t r;
		r = '0;
		for (int y = 0; y < GRID_SIDE; y++) begin
			for (int x = 0; x < GRID_SIDE; x++) begin
				if (b[x * GRID_SIDE + (GRID_SIDE - 1 - y)]) begin
					r[y * GRID_SIDE + x] = 1'b1;
				end
			end
		end
		return r;
	endfunction

	// transpose: cell (y, x) takes old cell (x, y)
	function automatic piece_t flip_diag(input piece_t b);
		piece_t r;
		r = '0;
		for (int y = 0; y < GRID_SIDE; y++) begin
			for (int x = 0; x < GRID_SIDE; x++) begin
				if (b[x * GRID_SIDE + y]) begin
					r[y * GRID_SIDE + x] = 1'b1;
				end
			end
		end
		return r;
	endfunction

	// slide the occupied cells into the top-left corner
	function automatic piece_t snap_corner(input piece_t b);
		piece_t r;
		int     top;
		int     left;
		r    = '0;
		top  = GRID_SIDE;
		left = GRID_SIDE;
		for (int y = 0; y < GRID_SIDE; y++) begin
			for (int x = 0; x < GRID_SIDE; x++) begin
				if (b[y * GRID_SIDE + x]) begin
					if (y < top) top = y;
					if (x < left) left = x;
				end
			end
		end
		if (top == GRID_SIDE) begin
			return '0;
		end
		for (int y = top; y < GRID_SIDE; y++) begin
			for (int x = left; x < GRID_SIDE; x++) begin
				if (b[y * GRID_SIDE + x]) begin
					r[(y - top) * GRID_SIDE + (x - left)] = 1'b1;
				end
			end
		end
		return r;
	endfunction

	// queue the distinct orientations of one piece in output order
	function automatic void forecast_poses(input piece_t s);
		piece_t cand[2 * ROT_STEPS + 1];
		piece_t kept[MAX_POSES];
		piece_t f;
		pose_t  p;
		int     n;
		int     w;
		int     h;
		logic   dup;
		cand[0] = s;
		f = s;
		for (int i = 0; i < ROT_STEPS; i++) begin
			f = snap_corner(turn_left(f));
			cand[1 + i] = f;
		end
		// mirrored set starts from the piece as given, not from the last turn
		f = flip_diag(s);
		for (int i = 0; i < ROT_STEPS; i++) begin
			f = snap_corner(turn_left(f));
			cand[1 + ROT_STEPS + i] = f;
		end
		n = 0;
		for (int k = 0; k < 2 * ROT_STEPS + 1; k++) begin
			dup = 1'b0;
			for (int j = 0; j < n; j++) begin
				if (kept[j] == cand[k]) dup = 1'b1;
			end
			if (!dup && n < MAX_POSES) begin
				kept[n] = cand[k];
				n++;
			end
		end
		for (int k = 0; k < n; k++) begin
			w = 0;
			h = 0;
			for (int y = 0; y < GRID_SIDE; y++) begin
				for (int x = 0; x < GRID_SIDE; x++) begin
					if (kept[k][y * GRID_SIDE + x]) begin
						if (x + 1 > w) w = x + 1;
						if (y + 1 > h) h = y + 1;
					end
				end
			end
			p.bits  = kept[k];
			p.index = IDX_W'(k);
			p.wid   = DIM_W'(w);
			p.hgt   = DIM_W'(h);
			p.last  = (k == n - 1);
			poses_due.push_back(p);
		end
	endfunction

	// shape driver: keeps tvalid up until the transfer, predicts on every transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				forecast_poses(s_axis_tdata[SHAPE_W-1:0]);
				pieces_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pieces_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= S_TDATA_W'(pieces_q.pop_front());
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// pose monitor: random back-pressure, compares every transfer with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : pose_monitor
		pose_t want;
		pose_t got;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
			if (m_axis_tvalid && m_axis_tready) begin
				got.bits  = m_axis_tdata[SHAPE_W-1:0];
				got.index = m_axis_tdata[SHAPE_W +: IDX_W];
				got.wid   = m_axis_tdata[SHAPE_W + IDX_W +: DIM_W];
				got.hgt   = m_axis_tdata[SHAPE_W + IDX_W + DIM_W +: DIM_W];
				got.last  = m_axis_tlast;
				if (poses_due.size() == 0) begin
					$display("%0t: unexpected pose transfer, got bits %h index %0d",
						$time, got.bits, got.index);
					faults++;
				end else begin
					want = poses_due.pop_front();
					poses_checked++;
					if (got.bits !== want.bits) begin
						$display("%0t: pose_bits expected %h got %h", $time, want.bits, got.bits);
						faults++;
					end
					if (got.index !== want.index) begin
						$display("%0t: pose_index expected %0d got %0d",
							$time, want.index, got.index);
						faults++;
					end
					if (got.wid !== want.wid) begin
						$display("%0t: pose_width expected %0d got %0d", $time, want.wid, got.wid);
						faults++;
					end
					if (got.hgt !== want.hgt) begin
						$display("%0t: pose_height expected %0d got %0d", $time, want.hgt, got.hgt);
						faults++;
					end
					if (got.last !== want.last) begin
						$display("%0t: last_pose expected %0b got %0b", $time, want.last, got.last);
						faults++;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d poses outstanding", $time, poses_due.size());
			$display("** polyomino_pose_generator_top: FAILED **");
			$finish;
		end
	end

	// hold the sender back until every queued piece has gone and every pose has arrived
	task automatic wait_drained();
		@(posedge clk);
		while (pieces_q.size() != 0 || s_axis_tvalid || poses_due.size() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		piece_t b;
		int     pick;
		int     size;
		int     grown;
		int     tries;
		int     y;
		int     x;
		int     pos;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty, full, edges of the grid, symmetric and asymmetric pieces
		pieces_q.push_back('0);                          // empty piece, one pose of size 0
		pieces_q.push_back({SHAPE_W{1'b1}});             // whole grid
		pieces_q.push_back(piece_t'(1));                 // single corner cell
		pieces_q.push_back(piece_t'(1) << (SHAPE_W - 1)); // single far cell, not packed
		pieces_q.push_back(49'h0_0000_0000_0183);        // square, one pose
		pieces_q.push_back(49'h0_0000_0000_8382);        // plus sign, one pose
		pieces_q.push_back(49'h0_0000_0000_000F);        // straight four, two poses
		pieces_q.push_back(49'h0_0000_0000_0107);        // tee, four poses
		pieces_q.push_back(49'h0_0000_0000_0186);        // skew four
		pieces_q.push_back(49'h0_0000_0000_C081);        // ell, eight poses
		pieces_q.push_back(49'h0_0001_8102_0000);        // ell away from the corner
		pieces_q.push_back(49'h0_0000_0180_0000);        // domino in mid grid
		pieces_q.push_back(49'h0_0000_0000_007F);        // full top row, width 7
		pieces_q.push_back(49'h0_0408_1020_4081);        // full left column, height 7
		pieces_q.push_back(49'h1_FC00_0000_0000);        // full bottom row, not packed
		pieces_q.push_back(49'h1_5555_5555_5555);        // checker patterns, every bit both ways
		pieces_q.push_back(49'h0_AAAA_AAAA_AAAA);
		wait_drained();

		// random: mostly grown polyominoes, some noise; drain between the two halves
		for (int phase = 0; phase < 2; phase++) begin
			for (int n = 0; n < RANDOM_HALF; n++) begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					size  = $urandom_range(12, 1);
					b     = '0;
					b[$urandom_range(SHAPE_W - 1)] = 1'b1;
					grown = 1;
					tries = 0;
					while (grown < size && tries < 4000) begin
						tries++;
						y   = $urandom_range(GRID_SIDE - 1);
						x   = $urandom_range(GRID_SIDE - 1);
						pos = y * GRID_SIDE + x;
						if (!b[pos] &&
						    ((y > 0 && b[pos - GRID_SIDE]) ||
						     (y < GRID_SIDE - 1 && b[pos + GRID_SIDE]) ||
						     (x > 0 && b[pos - 1]) ||
						     (x < GRID_SIDE - 1 && b[pos + 1]))) begin
							b[pos] = 1'b1;
							grown++;
						end
					end
					// most pieces arrive packed, the rest sit wherever they grew
					if ($urandom_range(2) != 0) b = snap_corner(b);
				end else if (pick < 85) begin
					b = piece_t'({$urandom, $urandom});
				end else begin
					b = '0;
					repeat ($urandom_range(4, 1)) b[$urandom_range(SHAPE_W - 1)] = 1'b1;
				end
				pieces_q.push_back(b);
			end
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d pieces (directed edges and symmetries, grown polyominoes, noise)",
			pieces_sent);
		$display("checked %0d poses under random idling and back-pressure, %0d mismatches",
			poses_checked, faults);
		if (faults == 0 && poses_due.size() == 0) begin
			$display("** polyomino_pose_generator_top: PASSED **");
		end else begin
			$display("** polyomino_pose_generator_top: FAILED **");
		end
		$finish;
	end

endmodule
